>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication with the consequent checked in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rtfp_pkg.sv
package rtfp_pkg;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_COUNT  = 3'd2;
    localparam logic [2:0] ST_LONG   = 3'd3;
    localparam logic [2:0] ST_FOOTER = 3'd4;

    localparam logic [7:0] ANGLE_BIAS   = 8'h80;
    localparam int         RESULT_LIMIT = 8;
    localparam int         TARGET_BYTES = 5;

    // Frame summary handed from the byte parser to the result sequencer.
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] count;
    } frame_cmd_t;

    function automatic logic [7:0] header_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hF4;
            2'd1:    b = 8'hF3;
            2'd2:    b = 8'hF2;
            default: b = 8'hF1;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] footer_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hF8;
            2'd1:    b = 8'hF7;
            2'd2:    b = 8'hF6;
            default: b = 8'hF5;
        endcase
        return b;
    endfunction

endpackage

>>> design/rtfp_front.sv
module rtfp_front #(
    parameter int MAX_PAYLOAD = 64,
    parameter int MAX_TARGETS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rx_valid,
    output logic                         rx_stall,
    input  logic [7:0]                   rx_byte,
    input  logic                         back_pending,
    input  logic                         q_full,
    output logic                         push,
    output rtfp_pkg::frame_cmd_t         cmd,
    output logic                         wr_en,
    output logic [$clog2(MAX_PAYLOAD)-1:0] wr_addr,
    output logic [7:0]                   wr_data
);

    localparam int AW  = $clog2(MAX_PAYLOAD);
    localparam int CW  = $clog2(MAX_PAYLOAD + 1);
    localparam int LIM = (MAX_TARGETS < rtfp_pkg::RESULT_LIMIT) ?
                         MAX_TARGETS : rtfp_pkg::RESULT_LIMIT;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_FOOT   = 3'd4;

    logic [2:0]    phase_reg, phase_next;
    logic [1:0]    hdr_reg, hdr_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    ftr_reg, ftr_next;
    logic          ferr_reg, ferr_next;
    logic [7:0]    tcount_reg;

    logic          accept;
    logic [15:0]   full_len;
    logic [CW-1:0] cnt_inc;
    logic          foot_err;
    logic [15:0]   need;
    logic [15:0]   len16;
    logic [3:0]    clamped;
    rtfp_pkg::frame_cmd_t frame_cmd;

    // Input stalls while the queue is full; payload writes also wait until earlier frames are read out.
    assign rx_stall = q_full || ((phase_reg == PH_DATA) && back_pending);
    assign accept   = rx_valid && !rx_stall;

    assign full_len = {rx_byte, len_lo_reg};
    assign cnt_inc  = cnt_reg + CW'(1);
    assign foot_err = ferr_reg || (rx_byte != rtfp_pkg::footer_byte(ftr_reg));

    assign need    = 16'd2 + ({8'd0, tcount_reg} << 2) + {8'd0, tcount_reg};
    assign len16   = {{(16-CW){1'b0}}, len_reg};
    assign clamped = (tcount_reg > 8'(LIM)) ? 4'(LIM) : tcount_reg[3:0];

    always_comb
    begin
        if (foot_err)
        begin
            frame_cmd.status = rtfp_pkg::ST_FOOTER;
            frame_cmd.count  = 4'd0;
        end
        else if (len16 < 16'd2)
        begin
            frame_cmd.status = rtfp_pkg::ST_SHORT;
            frame_cmd.count  = 4'd0;
        end
        else if (need > len16)
        begin
            frame_cmd.status = rtfp_pkg::ST_COUNT;
            frame_cmd.count  = 4'd0;
        end
        else
        begin
            frame_cmd.status = rtfp_pkg::ST_OK;
            frame_cmd.count  = clamped;
        end
    end

    assign wr_en   = accept && (phase_reg == PH_DATA);
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = rx_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        len_lo_next = len_lo_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        ftr_next    = ftr_reg;
        ferr_next   = ferr_reg;
        push        = 1'b0;
        cmd         = frame_cmd;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == rtfp_pkg::header_byte(hdr_reg))
                    begin
                        if (hdr_reg == 2'd3)
                        begin
                            hdr_next   = 2'd0;
                            phase_next = PH_LEN_LO;
                        end
                        else
                        begin
                            hdr_next = hdr_reg + 2'd1;
                        end
                    end
                    else if (rx_byte == rtfp_pkg::header_byte(2'd0))
                    begin
                        hdr_next = 2'd1;
                    end
                    else
                    begin
                        hdr_next = 2'd0;
                    end
                end
                PH_LEN_LO:
                begin
                    len_lo_next = rx_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next  = full_len[CW-1:0];
                    cnt_next  = '0;
                    ftr_next  = 2'd0;
                    ferr_next = 1'b0;
                    if (full_len > 16'(MAX_PAYLOAD))
                    begin
                        push         = 1'b1;
                        cmd.status   = rtfp_pkg::ST_LONG;
                        cmd.count    = 4'd0;
                        phase_next   = PH_HUNT;
                    end
                    else if (full_len == 16'd0)
                    begin
                        phase_next = PH_FOOT;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= len_reg)
                    begin
                        ftr_next   = 2'd0;
                        ferr_next  = 1'b0;
                        phase_next = PH_FOOT;
                    end
                end
                PH_FOOT:
                begin
                    if (ftr_reg == 2'd3)
                    begin
                        push       = 1'b1;
                        ftr_next   = 2'd0;
                        ferr_next  = 1'b0;
                        hdr_next   = 2'd0;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        ftr_next  = ftr_reg + 2'd1;
                        ferr_next = foot_err;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    hdr_next   = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            hdr_reg    <= 2'd0;
            len_lo_reg <= 8'd0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            ftr_reg    <= 2'd0;
            ferr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            len_lo_reg <= len_lo_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            ftr_reg    <= ftr_next;
            ferr_reg   <= ferr_next;
        end
    end

    // Target count is payload byte 1.
    always_ff @(posedge clk)
    begin
        if (wr_en && (cnt_reg == CW'(1)))
        begin
            tcount_reg <= rx_byte;
        end
    end

endmodule

>>> design/rtfp_queue.sv
module rtfp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rtfp_pkg::frame_cmd_t push_cmd,
    input  logic                 pop,
    output rtfp_pkg::frame_cmd_t head_cmd,
    output logic                 not_empty,
    output logic                 full
);

    rtfp_pkg::frame_cmd_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] level_reg;

    assign not_empty = (level_reg != 2'd0);
    assign full      = (level_reg == 2'd2);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/rtfp_back.sv
module rtfp_back #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [$clog2(MAX_PAYLOAD)-1:0] wr_addr,
    input  logic [7:0]                     wr_data,
    input  logic                           cmd_valid,
    input  rtfp_pkg::frame_cmd_t           cmd,
    output logic                           pop,
    output logic                           busy,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [2:0]                     frame_status,
    output logic                           target_valid,
    output logic [2:0]                     target_index,
    output logic [3:0]                     target_count,
    output logic signed [7:0]              angle,
    output logic [7:0]                     distance,
    output logic [7:0]                     direction,
    output logic [7:0]                     speed,
    output logic [7:0]                     snr,
    output logic                           last
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LAND = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [7:0]    mem [MAX_PAYLOAD];
    logic [7:0]    rd_data_reg;
    logic          rd_v_reg;

    logic [1:0]    state_reg;
    logic [AW-1:0] addr_reg;
    logic [2:0]    k_reg;
    logic [2:0]    idx_reg;
    logic [3:0]    tcnt_reg;
    logic [7:0]    fld_reg [5];

    logic          out_v_reg;
    logic          slot_free;
    logic          status_only;
    logic          is_last;

    assign slot_free   = !out_v_reg || !res_stall;
    assign status_only = (cmd.status != rtfp_pkg::ST_OK) || (cmd.count == 4'd0);
    assign is_last     = ({1'b0, idx_reg} + 4'd1) == tcnt_reg;
    assign pop         = (state_reg == S_IDLE) && cmd_valid && (!status_only || slot_free);
    assign busy        = (state_reg != S_IDLE);
    assign res_valid   = out_v_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[addr_reg];
        end
        // Target bytes shift in; after five reads fld_reg[0] holds the angle.
        if (rd_v_reg)
        begin
            fld_reg[4] <= rd_data_reg;
            for (int i = 0; i < 4; i++)
            begin
                fld_reg[i] <= fld_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rd_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            addr_reg  <= '0;
            k_reg     <= 3'd0;
            idx_reg   <= 3'd0;
            tcnt_reg  <= 4'd0;
        end
        else
        begin
            rd_v_reg <= (state_reg == S_READ);
            if (out_v_reg && !res_stall)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && status_only)
                    begin
                        out_v_reg <= 1'b1;
                    end
                    else if (pop)
                    begin
                        addr_reg  <= AW'(2);
                        k_reg     <= 3'd0;
                        idx_reg   <= 3'd0;
                        tcnt_reg  <= cmd.count;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    k_reg    <= k_reg + 3'd1;
                    if (k_reg == 3'(rtfp_pkg::TARGET_BYTES - 1))
                    begin
                        state_reg <= S_LAND;
                    end
                end
                S_LAND:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        out_v_reg <= 1'b1;
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            k_reg     <= 3'd0;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result word registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && pop && status_only)
        begin
            frame_status <= cmd.status;
            target_valid <= 1'b0;
            target_index <= 3'd0;
            target_count <= 4'd0;
            angle        <= 8'sd0;
            distance     <= 8'd0;
            direction    <= 8'd0;
            speed        <= 8'd0;
            snr          <= 8'd0;
            last         <= 1'b1;
        end
        else if ((state_reg == S_OUT) && slot_free)
        begin
            frame_status <= rtfp_pkg::ST_OK;
            target_valid <= 1'b1;
            target_index <= idx_reg;
            target_count <= tcnt_reg;
            angle        <= $signed(fld_reg[0] - rtfp_pkg::ANGLE_BIAS);
            distance     <= fld_reg[1];
            direction    <= fld_reg[2];
            speed        <= fld_reg[3];
            snr          <= fld_reg[4];
            last         <= is_last;
        end
    end

endmodule

>>> design/radar_target_frame_parser.sv
// Radar target frame parser.
// Input channel: one serial byte per word on rx_byte, rx_valid/rx_stall.
// Output channel: one result word per target, or a single status word per
// frame, on res_valid/res_stall; last marks the final word of a frame.
// A frame is header F4 F3 F2 F1, 16-bit little-endian length, payload,
// footer F8 F7 F6 F5. Results follow the footer, or an over-long length field.
// Bytes are taken at one per cycle; rx_stall rises only when the frame queue
// (two entries) is full, or when payload bytes of a new frame arrive while an
// earlier frame is still queued or still being read from the payload memory.
// A status word passes through the frame queue and then the output register;
// each target takes five single-port memory reads (S_READ), a landing state
// (S_LAND) and an output load (S_OUT). A stalled result word holds until
// taken. Reset clears the parser to header hunt and empties the queue and
// output register; payload memory is not cleared and needs no clearing
// pass.
module radar_target_frame_parser #(
    parameter int MAX_PAYLOAD = 64,
    parameter int MAX_TARGETS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [2:0]        frame_status,
    output logic              target_valid,
    output logic [2:0]        target_index,
    output logic [3:0]        target_count,
    output logic signed [7:0] angle,
    output logic [7:0]        distance,
    output logic [7:0]        direction,
    output logic [7:0]        speed,
    output logic [7:0]        snr,
    output logic              last
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    logic                 push, pop, q_full, q_not_empty, back_busy;
    rtfp_pkg::frame_cmd_t push_cmd, head_cmd;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;

    rtfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_TARGETS (MAX_TARGETS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .back_pending (back_busy || q_not_empty),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    rtfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    rtfp_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .cmd_valid    (q_not_empty),
        .cmd          (head_cmd),
        .pop          (pop),
        .busy         (back_busy),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .frame_status (frame_status),
        .target_valid (target_valid),
        .target_index (target_index),
        .target_count (target_count),
        .angle        (angle),
        .distance     (distance),
        .direction    (direction),
        .speed        (speed),
        .snr          (snr),
        .last         (last)
    );

endmodule

>>> design/rtfp_checker.sv
`include "assert_macros.svh"

module rtfp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_stall,
    input logic [2:0]        frame_status,
    input logic              target_valid,
    input logic [2:0]        target_index,
    input logic [3:0]        target_count,
    input logic signed [7:0] angle,
    input logic              last
);

    `CHK_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(target_index) && $stable(angle) && $stable(last), "stalled result word changed")

    `CHK_ASSERT(a_target_ok, !(res_valid && target_valid) || (frame_status == rtfp_pkg::ST_OK), "target word with nonzero status")

    `CHK_ASSERT(a_status_word, !(res_valid && !target_valid) || (last && (target_count == 4'd0)), "status word not last or with count")

    `CHK_ASSERT(a_index_last, !(res_valid && target_valid) || (({1'b0, target_index} < target_count) && (last == (({1'b0, target_index} + 4'd1) == target_count))), "target index or last inconsistent")

endmodule

bind radar_target_frame_parser rtfp_checker u_rtfp_checker (.*);

>>> tb/radar_target_frame_parser_test.sv
`timescale 1ns / 100ps

module radar_target_frame_parser_test;
    import rtfp_pkg::*;

    localparam int MAX_PAYLOAD  = 64;
    localparam int MAX_TARGETS  = 8;
    localparam int ITEMS        = 250;
    localparam int MIN_WORDS    = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int N_ROWS       = 15;

    localparam logic [31:0] HDR_SEQ = 32'hF4F3F2F1;
    localparam logic [31:0] FTR_SEQ = 32'hF8F7F6F5;

    typedef enum logic [2:0] {PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_FOOT} parse_phase_e;
    typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_MID} fill_e;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY3} stall_mode_e;

    typedef struct packed {
        logic [2:0] status;
        logic       tvalid;
        logic [2:0] index;
        logic [3:0] count;
        logic [7:0] angle;
        logic [7:0] distance;
        logic [7:0] direction;
        logic [7:0] speed;
        logic [7:0] snr;
        logic       last;
    } target_word_t;

    typedef struct packed {
        logic [1:0]  prefix;
        logic [15:0] len;
        logic [7:0]  cnt;
        fill_e       fill;
        logic [2:0]  bad_pos;
        logic        typed;
        logic [2:0]  st;
    } frame_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              rx_valid;
    logic              rx_stall;
    logic [7:0]        rx_byte;
    logic              res_valid;
    logic              res_stall;
    logic [2:0]        frame_status;
    logic              target_valid;
    logic [2:0]        target_index;
    logic [3:0]        target_count;
    logic signed [7:0] angle;
    logic [7:0]        distance;
    logic [7:0]        direction;
    logic [7:0]        speed;
    logic [7:0]        snr;
    logic              last;

    // parser state mirrored by the predictor
    parse_phase_e p_phase   = PH_HUNT;
    logic [1:0]   hdr_hits  = '0;
    logic [7:0]   len_low   = '0;
    logic [15:0]  frame_len = '0;
    logic [15:0]  data_cnt  = '0;
    logic [1:0]   ftr_hits  = '0;
    logic         ftr_bad   = 1'b0;
    logic [7:0]   payload_mem [MAX_PAYLOAD];

    target_word_t new_words [$];
    target_word_t expected_words [$];
    frame_row_t   dir_rows [N_ROWS];

    int  mismatches     = 0;
    int  bytes_sent     = 0;
    int  noise_bytes    = 0;
    int  frames_sent    = 0;
    int  words_expected = 0;
    int  words_checked  = 0;
    int  targets_seen   = 0;
    int  idle_cycles    = 0;
    int  burst_left     = 0;
    bit  gaps_on        = 1'b0;
    bit  hold_off_req   = 1'b0;

    radar_target_frame_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .MAX_TARGETS(MAX_TARGETS)
    ) u_top (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] seq_byte(input logic [31:0] seq, input int idx);
        return 8'(seq >> (8 * (3 - idx)));
    endfunction

    task automatic push_status(input logic [2:0] st);
        target_word_t w;
        w = '0;
        w.status = st;
        w.last = 1'b1;
        new_words.push_back(w);
    endtask

    // Advances the mirrored parser by one byte; finished frames land in new_words.
    task automatic parse_rx_byte(input logic [7:0] b);
        target_word_t w;
        int n;
        int lim;
        int base;
        case (p_phase)
            PH_HUNT:
            begin
                if (b == seq_byte(HDR_SEQ, hdr_hits))
                begin
                    if (hdr_hits == 2'd3)
                    begin
                        hdr_hits = '0;
                        p_phase = PH_LEN_LO;
                    end
                    else
                        hdr_hits++;
                end
                else if (b == seq_byte(HDR_SEQ, 0))
                    hdr_hits = 2'd1;
                else
                    hdr_hits = '0;
            end
            PH_LEN_LO:
            begin
                len_low = b;
                p_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_len = {b, len_low};
                data_cnt = '0;
                ftr_hits = '0;
                ftr_bad = 1'b0;
                if (frame_len > MAX_PAYLOAD)
                begin
                    push_status(ST_LONG);
                    p_phase = PH_HUNT;
                end
                else if (frame_len == 0)
                    p_phase = PH_FOOT;
                else
                    p_phase = PH_DATA;
            end
            PH_DATA:
            begin
                if (data_cnt < MAX_PAYLOAD)
                    payload_mem[data_cnt] = b;
                data_cnt++;
                if (data_cnt >= frame_len)
                begin
                    ftr_hits = '0;
                    ftr_bad = 1'b0;
                    p_phase = PH_FOOT;
                end
            end
            PH_FOOT:
            begin
                if (b != seq_byte(FTR_SEQ, ftr_hits))
                    ftr_bad = 1'b1;
                if (ftr_hits == 2'd3)
                begin
                    if (ftr_bad)
                        push_status(ST_FOOTER);
                    else if (frame_len < 2)
                        push_status(ST_SHORT);
                    else
                    begin
                        n = payload_mem[1];
                        if (2 + n * TARGET_BYTES > frame_len)
                            push_status(ST_COUNT);
                        else
                        begin
                            lim = (MAX_TARGETS < RESULT_LIMIT) ? MAX_TARGETS : RESULT_LIMIT;
                            if (n > lim)
                                n = lim;
                            if (n == 0)
                                push_status(ST_OK);
                            for (int i = 0; i < n; i++)
                            begin
                                base = 2 + i * TARGET_BYTES;
                                w = '0;
                                w.status = ST_OK;
                                w.tvalid = 1'b1;
                                w.index = 3'(i);
                                w.count = 4'(n);
                                w.angle = payload_mem[base] - ANGLE_BIAS;
                                w.distance = payload_mem[base + 1];
                                w.direction = payload_mem[base + 2];
                                w.speed = payload_mem[base + 3];
                                w.snr = payload_mem[base + 4];
                                w.last = (i == n - 1);
                                new_words.push_back(w);
                            end
                        end
                    end
                    ftr_hits = '0;
                    ftr_bad = 1'b0;
                    hdr_hits = '0;
                    p_phase = PH_HUNT;
                end
                else
                    ftr_hits++;
            end
            default:
            begin
                p_phase = PH_HUNT;
                hdr_hits = '0;
            end
        endcase
    endtask

    // Offers one byte and waits until it is taken. With typed set, the status
    // word given by the caller replaces whatever the predictor produced.
    task automatic put_byte(input logic [7:0] b, input bit typed, input logic [2:0] st);
        target_word_t w;
        if (gaps_on && burst_left == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        bytes_sent++;
        parse_rx_byte(b);
        if (new_words.size() != 0)
        begin
            if (typed)
            begin
                w = '0;
                w.status = st;
                w.last = 1'b1;
                expected_words.push_back(w);
                words_expected++;
            end
            else
            begin
                foreach (new_words[i])
                    expected_words.push_back(new_words[i]);
                words_expected += new_words.size();
            end
            new_words.delete();
        end
    endtask

    task automatic send_frame(input int prefix, input logic [15:0] len, input logic [7:0] cnt,
                              input fill_e fill, input int bad_pos, input bit typed,
                              input logic [2:0] st);
        logic [7:0] b;
        for (int i = 0; i < prefix; i++)
            put_byte(seq_byte(HDR_SEQ, i), typed, st);
        for (int i = 0; i < 4; i++)
            put_byte(seq_byte(HDR_SEQ, i), typed, st);
        put_byte(len[7:0], typed, st);
        put_byte(len[15:8], typed, st);
        if (len <= MAX_PAYLOAD)
        begin
            for (int i = 0; i < len; i++)
            begin
                case (fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hFF;
                    FILL_MID:  b = 8'h80;
                    default:   b = 8'($urandom);
                endcase
                if (i == 1)
                    b = cnt;
                put_byte(b, typed, st);
            end
            for (int i = 0; i < 4; i++)
            begin
                b = seq_byte(FTR_SEQ, i);
                if (bad_pos == i + 1)
                    b = b ^ 8'($urandom_range(1, 255));
                put_byte(b, typed, st);
            end
        end
        frames_sent++;
    endtask

    task automatic send_random_frame();
        int pick;
        int n;
        int max_extra;
        int prefix;
        int k;
        logic [15:0] len;
        logic [7:0]  cnt;
        pick = $urandom_range(0, 99);
        prefix = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        max_extra = 62 - 5 * n;
        if (max_extra > 3)
            max_extra = 3;
        len = 16'(2 + 5 * n + $urandom_range(0, max_extra));
        cnt = 8'(n);
        if (pick < 55)
            send_frame(prefix, len, cnt, FILL_RAND, 0, 1'b0, ST_OK);
        else if (pick < 70)
        begin
            len = 16'($urandom_range(2, MAX_PAYLOAD));
            cnt = 8'($urandom_range((len - 2) / 5 + 1, 255));
            send_frame(prefix, len, cnt, FILL_RAND, 0, 1'b0, ST_OK);
        end
        else if (pick < 75)
            send_frame(prefix, 16'($urandom_range(0, 1)), cnt, FILL_RAND, 0, 1'b0, ST_OK);
        else if (pick < 85)
            send_frame(prefix, 16'($urandom_range(MAX_PAYLOAD + 1, 65535)), cnt, FILL_RAND,
                       0, 1'b0, ST_OK);
        else if (pick < 95)
            send_frame(prefix, len, cnt, FILL_RAND, $urandom_range(1, 4), 1'b0, ST_OK);
        else
        begin
            // line noise, biased toward header bytes to exercise partial matches
            repeat ($urandom_range(1, 10))
            begin
                k = $urandom_range(0, 5);
                put_byte((k < 4) ? seq_byte(HDR_SEQ, k) : 8'($urandom), 1'b0, ST_OK);
                noise_bytes++;
            end
        end
    endtask

    task automatic drain_results();
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        target_word_t exp_w;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: status %0d index %0d", frame_status,
                       target_index);
                mismatches++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                check_field("frame_status", exp_w.status, frame_status);
                check_field("target_valid", exp_w.tvalid, target_valid);
                check_field("target_index", exp_w.index, target_index);
                check_field("target_count", exp_w.count, target_count);
                check_field("angle", exp_w.angle, angle);
                check_field("distance", exp_w.distance, distance);
                check_field("direction", exp_w.direction, direction);
                check_field("speed", exp_w.speed, speed);
                check_field("snr", exp_w.snr, snr);
                check_field("last", exp_w.last, last);
                words_checked++;
                if (exp_w.tvalid)
                    targets_seen++;
            end
        end
    end

    // receiver back-pressure; a requested hold-off is timed here
    initial
    begin
        stall_mode_e mode;
        int left;
        res_stall = 1'b0;
        mode = STALL_NONE;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            if (left == 0)
            begin
                mode = stall_mode_e'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                STALL_NONE:  res_stall <= 1'b0;
                STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
                default:     res_stall <= (left % 3 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else if (++idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int rand_words0;
        int rand_bytes0;
        rst_n    = 1'b0;
        rx_valid = 1'b0;
        rx_byte  = 8'h00;

        dir_rows[0]  = '{2'd2, 16'd0,      8'd0,   FILL_RAND, 3'd0, 1'b1, ST_SHORT};
        dir_rows[1]  = '{2'd3, 16'd1,      8'd0,   FILL_RAND, 3'd0, 1'b1, ST_SHORT};
        dir_rows[2]  = '{2'd0, 16'd65,     8'd0,   FILL_RAND, 3'd0, 1'b1, ST_LONG};
        dir_rows[3]  = '{2'd0, 16'hFFFF,   8'd0,   FILL_RAND, 3'd0, 1'b1, ST_LONG};
        dir_rows[4]  = '{2'd0, 16'd2,      8'd0,   FILL_RAND, 3'd0, 1'b1, ST_OK};
        dir_rows[5]  = '{2'd0, 16'd2,      8'd1,   FILL_RAND, 3'd0, 1'b1, ST_COUNT};
        dir_rows[6]  = '{2'd0, 16'd6,      8'd1,   FILL_RAND, 3'd0, 1'b1, ST_COUNT};
        dir_rows[7]  = '{2'd0, 16'd64,     8'd255, FILL_RAND, 3'd0, 1'b1, ST_COUNT};
        dir_rows[8]  = '{2'd0, 16'd7,      8'd1,   FILL_ZERO, 3'd0, 1'b0, ST_OK};
        dir_rows[9]  = '{2'd0, 16'd7,      8'd1,   FILL_ONES, 3'd0, 1'b0, ST_OK};
        dir_rows[10] = '{2'd0, 16'd42,     8'd8,   FILL_MID,  3'd0, 1'b0, ST_OK};
        dir_rows[11] = '{2'd0, 16'd64,     8'd12,  FILL_RAND, 3'd0, 1'b0, ST_OK};
        dir_rows[12] = '{2'd0, 16'd3,      8'd0,   FILL_RAND, 3'd4, 1'b1, ST_FOOTER};
        dir_rows[13] = '{2'd0, 16'd0,      8'd0,   FILL_RAND, 3'd1, 1'b1, ST_FOOTER};
        dir_rows[14] = '{2'd0, 16'd12,     8'd2,   FILL_RAND, 3'd2, 1'b1, ST_FOOTER};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        foreach (dir_rows[i])
            send_frame(dir_rows[i].prefix, dir_rows[i].len, dir_rows[i].cnt, dir_rows[i].fill,
                       dir_rows[i].bad_pos, dir_rows[i].typed, dir_rows[i].st);
        drain_results();

        // hold the output side off while status and target frames keep coming
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        repeat (6) send_frame(0, 16'h0100, 8'd0, FILL_RAND, 0, 1'b0, ST_OK);
        repeat (2) send_frame(0, 16'd12, 8'd2, FILL_RAND, 0, 1'b0, ST_OK);
        drain_results();

        rand_words0 = words_expected;
        rand_bytes0 = bytes_sent - noise_bytes;
        while (bytes_sent - noise_bytes - rand_bytes0 < ITEMS
               || words_expected - rand_words0 < MIN_WORDS)
        begin
            if (frames_sent % 8 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (frames_sent % 25 == 0)
                drain_results();
            send_random_frame();
        end

        rx_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d frames, %0d framed bytes and %0d noise bytes;",
                 frames_sent, bytes_sent - noise_bytes, noise_bytes);
        $display("checked %0d result words, %0d of them target records.",
                 words_checked, targets_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
